// ===== hw/rtl/exponential_chirp_torque_generator_core_assert.svh =====
// Assertion macros for the checker file of the chirp torque generator.
// Every macro samples on the rising edge of aclk and is disabled during reset.
`ifndef EXPONENTIAL_CHIRP_TORQUE_GENERATOR_CORE_ASSERT_SVH
`define EXPONENTIAL_CHIRP_TORQUE_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECTG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ectg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ECTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ectg assertion failed");

`endif

// ===== hw/rtl/ectg_pkg.sv =====
// ----------------------------------------------------------------------------
// ectg_pkg: shared definitions of the chirp torque generator
// Beat types, register codes, reset values and the quarter-wave sine tables.
// ----------------------------------------------------------------------------
package ectg_pkg;

    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int TABLE_BITS       = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER_BITS     = TABLE_BITS - 2;
    localparam int QUARTER_DEPTH    = SINE_TABLE_DEPTH / 4;

    localparam int STEP_BITS     = 32;
    localparam int GROWTH_BITS   = 31;
    localparam int GROWTH_FRAC   = 30;
    localparam int ELAPSED_BITS  = 17;
    localparam int MNM_BITS      = 11;
    localparam int TORQUE_BITS   = MNM_BITS + 1;
    localparam int SINE_MAG_BITS = 15;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [STEP_BITS-1:0]    START_STEP_RESET   = 32'd858993;
    localparam logic [GROWTH_BITS-1:0]  GROWTH_RESET       = 31'd1073802692;
    localparam logic [ELAPSED_BITS-1:0] SWEEP_LENGTH_RESET = 17'd60000;
    localparam logic [MNM_BITS-1:0]     PEAK_RESET         = 11'd800;
    localparam logic [MNM_BITS-1:0]     LIMIT_RESET        = 11'd1200;
    localparam logic                    REQUIRE_FREE_RESET = 1'b1;
    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX        = '1;

    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_STEP   = 3'd0,
        CFG_GROWTH       = 3'd1,
        CFG_SWEEP_LENGTH = 3'd2,
        CFG_PEAK         = 3'd3,
        CFG_LIMIT        = 3'd4,
        CFG_REQUIRE_FREE = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic motor_ready;
        logic base_mode_free;
    } in_beat_t;

    typedef struct packed {
        logic                     sweep_active;
        logic                     start_pulse;
        logic                     stop_pulse;
        logic                     hold_sync;
        logic [ELAPSED_BITS-1:0]  elapsed_ms;
        logic signed [TORQUE_BITS-1:0] torque_mnm;
    } out_beat_t;

    typedef struct packed {
        logic                  running;
        logic [TABLE_BITS-1:0] index;
    } shaper_req_t;

    typedef logic [SINE_MAG_BITS-1:0] quarter_rom_t [QUARTER_DEPTH];

    // One quarter-wave entry: sine series for even quadrants, cosine series for
    // odd ones, each a seven-term Taylor sum in Q30 and rounded to Q0.15.
    function automatic logic [SINE_MAG_BITS-1:0] quarter_entry(int r, bit use_cos);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint v;
        x  = (longint'(4 * r) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        x2 = (x * x) >>> 30;
        if (use_cos) begin
            term = ONE_Q30;
            sum  = term;
            term = ((term * x2) >>> 30) / 2;   sum = sum - term;
            term = ((term * x2) >>> 30) / 12;  sum = sum + term;
            term = ((term * x2) >>> 30) / 30;  sum = sum - term;
            term = ((term * x2) >>> 30) / 56;  sum = sum + term;
            term = ((term * x2) >>> 30) / 90;  sum = sum - term;
            term = ((term * x2) >>> 30) / 132; sum = sum + term;
        end else begin
            term = x;
            sum  = term;
            term = ((term * x2) >>> 30) / 6;   sum = sum - term;
            term = ((term * x2) >>> 30) / 20;  sum = sum + term;
            term = ((term * x2) >>> 30) / 42;  sum = sum - term;
            term = ((term * x2) >>> 30) / 72;  sum = sum + term;
            term = ((term * x2) >>> 30) / 110; sum = sum - term;
            term = ((term * x2) >>> 30) / 156; sum = sum + term;
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
        return v[SINE_MAG_BITS-1:0];
    endfunction

    function automatic quarter_rom_t build_quarter_rom(bit use_cos);
        quarter_rom_t rom;
        for (int r = 0; r < QUARTER_DEPTH; r++) begin
            rom[r] = quarter_entry(r, use_cos);
        end
        return rom;
    endfunction

    localparam quarter_rom_t SIN_ROM = build_quarter_rom(1'b0);
    localparam quarter_rom_t COS_ROM = build_quarter_rom(1'b1);

endpackage

// ===== hw/rtl/ectg_torque_shaper.sv =====
// ----------------------------------------------------------------------------
// ectg_torque_shaper: sine lookup, amplitude scaling and torque clamp
// Folds the table index into a quadrant, scales the Q0.15 magnitude by the
// peak value with rounding and limits the result symmetrically.
// ----------------------------------------------------------------------------
module ectg_torque_shaper (
    input  ectg_pkg::shaper_req_t                  req,
    input  logic [ectg_pkg::MNM_BITS-1:0]          peak_mnm,
    input  logic [ectg_pkg::MNM_BITS-1:0]          limit_mnm,
    output logic signed [ectg_pkg::TORQUE_BITS-1:0] torque_mnm
);

    localparam int PROD_BITS = ectg_pkg::SINE_MAG_BITS + ectg_pkg::MNM_BITS;

    logic [1:0]                           quad;
    logic [ectg_pkg::QUARTER_BITS-1:0]    rem;
    logic [ectg_pkg::SINE_MAG_BITS-1:0]   sine_mag;
    logic [PROD_BITS-1:0]                 scaled;
    logic [ectg_pkg::MNM_BITS-1:0]        mag;
    logic [ectg_pkg::MNM_BITS-1:0]        clamped;
    logic [ectg_pkg::TORQUE_BITS-1:0]     pos_torque;

    always_comb begin
        quad = req.index[ectg_pkg::TABLE_BITS-1 -: 2];
        rem  = req.index[ectg_pkg::QUARTER_BITS-1:0];
        // Odd quadrants read the cosine series, the upper half is negative.
        sine_mag = quad[0] ? ectg_pkg::COS_ROM[rem] : ectg_pkg::SIN_ROM[rem];
        scaled = PROD_BITS'(sine_mag) * PROD_BITS'(peak_mnm)
               + PROD_BITS'(1 << (ectg_pkg::SINE_MAG_BITS - 1));
        mag     = scaled[PROD_BITS-1 -: ectg_pkg::MNM_BITS];
        clamped = (mag > limit_mnm) ? limit_mnm : mag;
        pos_torque = {1'b0, clamped};
        if (!req.running) begin
            torque_mnm = '0;
        end else if (quad[1]) begin
            torque_mnm = $signed(~pos_torque + 1'b1);
        end else begin
            torque_mnm = $signed(pos_torque);
        end
    end

endmodule

// ===== hw/rtl/exponential_chirp_torque_generator_core.sv =====
// An accepted input beat passes the input register, the sweep state stage and the result register in turn.
// Throughput: one beat per cycle while the result channel does not stall.
// A stalled result beat holds all three stages in place.
// Reset (synchronous, active low) clears the sweep state, the stage valids and
// loads the register defaults; nothing else needs clearing.
// ----------------------------------------------------------------------------
// exponential_chirp_torque_generator_core: exponential sine sweep generator
// Input register, sweep state update with phase accumulator and step growth,
// then torque shaping into the result register.
// ----------------------------------------------------------------------------
module exponential_chirp_torque_generator_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  ectg_pkg::in_beat_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ectg_pkg::out_beat_t                  m_data,
    input  logic                                 cfg_we,
    input  logic [ectg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ectg_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    localparam int PROD_BITS  = ectg_pkg::STEP_BITS + ectg_pkg::GROWTH_BITS;
    localparam int GROWN_BITS = PROD_BITS - ectg_pkg::GROWTH_FRAC;

    typedef struct packed {
        logic                               sweep_active;
        logic                               start_pulse;
        logic                               stop_pulse;
        logic                               hold_sync;
        logic [ectg_pkg::ELAPSED_BITS-1:0]  elapsed_ms;
        ectg_pkg::shaper_req_t              req;
    } stage_b_t;

    // Configuration
    logic [ectg_pkg::STEP_BITS-1:0]    start_step_reg;
    logic [ectg_pkg::GROWTH_BITS-1:0]  growth_reg;
    logic [ectg_pkg::ELAPSED_BITS-1:0] length_reg;
    logic [ectg_pkg::MNM_BITS-1:0]     peak_reg;
    logic [ectg_pkg::MNM_BITS-1:0]     limit_reg;
    logic                              require_free_reg;

    // Sweep state
    logic                              active_reg, active_next;
    logic                              allowed_prev_reg, allowed_next;
    logic [ectg_pkg::ELAPSED_BITS-1:0] elapsed_reg, elapsed_next;
    logic [ectg_pkg::PHASE_BITS-1:0]   accum_reg, accum_next;
    logic [ectg_pkg::STEP_BITS-1:0]    step_reg, step_next;

    // Pipeline
    logic                  advance;
    logic                  a_valid_reg;
    ectg_pkg::in_beat_t    a_beat_reg;
    logic                  b_valid_reg;
    stage_b_t              b_reg, b_next;
    logic                  m_valid_reg;
    ectg_pkg::out_beat_t   m_data_reg;

    logic                                  rising;
    logic [ectg_pkg::ELAPSED_BITS-1:0]     elapsed_inc;
    logic [ectg_pkg::PHASE_BITS-1:0]       accum_sum;
    logic [PROD_BITS-1:0]                  product;
    logic [GROWN_BITS-1:0]                 grown;
    logic [ectg_pkg::STEP_BITS-1:0]        step_grown;
    logic signed [ectg_pkg::TORQUE_BITS-1:0] torque;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_step_reg   <= ectg_pkg::START_STEP_RESET;
            growth_reg       <= ectg_pkg::GROWTH_RESET;
            length_reg       <= ectg_pkg::SWEEP_LENGTH_RESET;
            peak_reg         <= ectg_pkg::PEAK_RESET;
            limit_reg        <= ectg_pkg::LIMIT_RESET;
            require_free_reg <= ectg_pkg::REQUIRE_FREE_RESET;
        end else if (cfg_we) begin
            unique case (ectg_pkg::cfg_reg_t'(cfg_index))
                ectg_pkg::CFG_START_STEP: begin
                    start_step_reg <= cfg_wdata[ectg_pkg::STEP_BITS-1:0];
                end
                ectg_pkg::CFG_GROWTH: begin
                    growth_reg <= cfg_wdata[ectg_pkg::GROWTH_BITS-1:0];
                end
                ectg_pkg::CFG_SWEEP_LENGTH: begin
                    length_reg <= cfg_wdata[ectg_pkg::ELAPSED_BITS-1:0];
                end
                ectg_pkg::CFG_PEAK: begin
                    peak_reg <= cfg_wdata[ectg_pkg::MNM_BITS-1:0];
                end
                ectg_pkg::CFG_LIMIT: begin
                    limit_reg <= cfg_wdata[ectg_pkg::MNM_BITS-1:0];
                end
                ectg_pkg::CFG_REQUIRE_FREE: begin
                    require_free_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sweep state update for the beat held in the input register.
    always_comb begin
        allowed_next = a_beat_reg.motor_ready
                     & (require_free_reg ? a_beat_reg.base_mode_free : 1'b1);
        rising       = allowed_next & ~allowed_prev_reg;
        elapsed_inc  = (elapsed_reg < ectg_pkg::ELAPSED_MAX) ? elapsed_reg + 1'b1
                                                              : elapsed_reg;
        accum_sum    = accum_reg + step_reg[ectg_pkg::PHASE_BITS-1:0];
        product      = PROD_BITS'(step_reg) * PROD_BITS'(growth_reg);
        grown        = product[PROD_BITS-1:ectg_pkg::GROWTH_FRAC];
        // A step that grows past 32 bits saturates.
        step_grown   = grown[GROWN_BITS-1:ectg_pkg::STEP_BITS] != '0 ? '1
                     : grown[ectg_pkg::STEP_BITS-1:0];

        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        accum_next   = accum_reg;
        step_next    = step_reg;
        b_next       = '0;
        b_next.req.index = accum_sum[ectg_pkg::PHASE_BITS-1 -: ectg_pkg::TABLE_BITS];

        if (!active_reg) begin
            if (rising) begin
                active_next         = 1'b1;
                elapsed_next        = '0;
                accum_next          = '0;
                step_next           = start_step_reg;
                b_next.start_pulse  = 1'b1;
                b_next.hold_sync    = 1'b1;
            end
        end else if (!allowed_next || elapsed_inc >= length_reg) begin
            // A drop of the allowed condition wins over the length check.
            active_next        = 1'b0;
            elapsed_next       = '0;
            b_next.stop_pulse  = 1'b1;
            b_next.hold_sync   = 1'b1;
        end else begin
            elapsed_next       = elapsed_inc;
            accum_next         = accum_sum;
            step_next          = step_grown;
            b_next.hold_sync   = 1'b1;
            b_next.elapsed_ms  = elapsed_inc;
            b_next.req.running = 1'b1;
        end
        b_next.sweep_active = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            allowed_prev_reg <= 1'b0;
            elapsed_reg      <= '0;
            accum_reg        <= '0;
            step_reg         <= '0;
        end else if (advance && a_valid_reg) begin
            active_reg       <= active_next;
            allowed_prev_reg <= allowed_next;
            elapsed_reg      <= elapsed_next;
            accum_reg        <= accum_next;
            step_reg         <= step_next;
        end
    end

    ectg_torque_shaper u_shaper (
        .req        (b_reg.req),
        .peak_mnm   (peak_reg),
        .limit_mnm  (limit_reg),
        .torque_mnm (torque)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_beat_reg              <= s_data;
            b_reg                   <= b_next;
            m_data_reg.sweep_active <= b_reg.sweep_active;
            m_data_reg.start_pulse  <= b_reg.start_pulse;
            m_data_reg.stop_pulse   <= b_reg.stop_pulse;
            m_data_reg.hold_sync    <= b_reg.hold_sync;
            m_data_reg.elapsed_ms   <= b_reg.elapsed_ms;
            m_data_reg.torque_mnm   <= torque;
        end
    end

endmodule

// ===== hw/rtl/ectg_checker.sv =====
// ----------------------------------------------------------------------------
// ectg_checker: port-level checks of the chirp torque generator
// Watches the result channel for stall behaviour and consistent pulse fields.
// ----------------------------------------------------------------------------
`include "exponential_chirp_torque_generator_core_assert.svh"

module ectg_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input ectg_pkg::out_beat_t m_data
);

    logic start_fields_ok;
    logic idle_fields_ok;
    logic hold_expected;

    assign start_fields_ok = m_data.sweep_active && !m_data.stop_pulse
                          && m_data.elapsed_ms == '0 && m_data.torque_mnm == '0;
    assign idle_fields_ok  = m_data.elapsed_ms == '0 && m_data.torque_mnm == '0;
    assign hold_expected   = m_data.start_pulse || m_data.stop_pulse || m_data.sweep_active;

    // A stalled result beat stays on the port unchanged.
    `ECTG_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_data))

    // A start beat reports an active sweep with no time or torque yet.
    `ECTG_ASSERT_SAME(a_start_beat, m_valid && m_data.start_pulse, start_fields_ok)

    // Idle and stop beats carry neither elapsed time nor torque.
    `ECTG_ASSERT_SAME(a_idle_beat, m_valid && !m_data.sweep_active, idle_fields_ok)

    // Hold targets follow the sweep on every start, stop and running beat.
    `ECTG_ASSERT_SAME(a_hold_sync, m_valid, m_data.hold_sync == hold_expected)

endmodule

bind exponential_chirp_torque_generator_core ectg_checker u_ectg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
